// File: sv/tps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle plane setup block.
// No dependencies; every other file imports this package.
package tps_pkg;

    localparam int IN_DW  = 216;   // nine 24-bit vertex coordinates
    localparam int OUT_DW = 208;   // 207 payload bits padded to whole bytes
    localparam int XW     = 124;   // normalized sum of squares
    localparam int LW     = 62;    // square root width
    localparam int NW     = 62;    // shifted numerator width
    localparam int QW     = 31;    // quotient width
    localparam int MW     = 50;    // cross product magnitude width
    localparam int SPW    = 17;    // specularity width

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0]     KIND_ORDINARY = 2'd0;
    localparam logic [SPW-1:0] ONE_Q16       = 17'd65536;
    localparam logic [QW-1:0]  ONE_Q30       = 31'h4000_0000;

    typedef struct packed {
        logic [2:0][NW-1:0] num;
        logic [2:0]         neg;
        logic [5:0]         k;
        logic [23:0]        v1x;
        logic [23:0]        v1y;
        logic [23:0]        v1z;
        logic [SPW-1:0]     spec;
        logic               degen;
    } t_sq_side;

    typedef struct packed {
        logic [XW-1:0] x;
        t_sq_side      side;
    } t_fifo_item;

    typedef struct packed {
        logic [2:0]     neg;
        logic [MW-1:0]  area;
        logic [23:0]    v1x;
        logic [23:0]    v1y;
        logic [23:0]    v1z;
        logic [SPW-1:0] spec;
        logic           degen;
    } t_div_side;

endpackage

// File: sv/triangle_plane_setup.sv
`timescale 1ns / 1ps
// Top level of the triangle plane setup block.
// Depends on tps_pkg, tps_front, tps_fifo and tps_back.
//
// Usage:
//   Each beat on the slave stream carries one triangle: nine signed Q12.12
//   vertex coordinates in tdata and the surface kind in tuser. Each beat on
//   the master stream carries one result: unit normal (Q1.30), area (Q26.24),
//   plane offset (Q13.30) and specularity (Q1.16) in tdata, the degenerate
//   flag in tuser. Exactly one result beat leaves per triangle, in order.
//   The configuration channel writes the ordinary-surface specularity; it is
//   always ready and should be written only while the block is empty.
//   Throughput is one triangle per cycle while the receiver takes results.
//   The depth is set mostly by the 63-stage square root and the 32-stage
//   normal divider.
//   A front pipeline (11 stages) feeds a 4-beat queue; the back pipeline
//   pops it. When the receiver stalls, the back pipeline and output register
//   hold; ready drops once the queue is full and the front's last stage is valid.
//   Reset (synchronous, active low) empties all stages and the queue and
//   sets the specularity register to 1.0.
module triangle_plane_setup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z (24 bits each)
    input  logic [tps_pkg::IN_DW-1:0]   i_s_axis_tdata,
    // surface_kind
    input  logic [1:0]                  i_s_axis_tuser,
    // master stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // normal_x, normal_y, normal_z (32 each), area (50), plane_offset (44),
    // specularity (17), one pad bit
    output logic [tps_pkg::OUT_DW-1:0]  o_m_axis_tdata,
    // degenerate
    output logic [0:0]                  o_m_axis_tuser,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tps_pkg::SPW-1:0]     i_cfg_data
);
    import tps_pkg::*;

    logic [SPW-1:0] r_spec_cfg;

    logic       w_front_en;
    logic       w_f_v;
    t_fifo_item w_f_item;
    logic       w_full;
    logic       w_empty;
    t_fifo_item w_q_item;
    logic       w_back_en;
    logic       w_pop;

    logic [31:0]    w_nx, w_ny, w_nz;
    logic [MW-1:0]  w_area;
    logic [43:0]    w_off;
    logic [SPW-1:0] w_spec;
    logic           w_degen;

    // config register; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec_cfg <= ONE_Q16;
        end else if (i_cfg_valid) begin
            r_spec_cfg <= i_cfg_data;
        end
    end

    // hold the front only while its last stage waits on a full queue
    assign w_front_en      = !(w_f_v && w_full);
    assign o_s_axis_tready = w_front_en;

    tps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_front_en),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_kind     (i_s_axis_tuser),
        .i_spec_cfg (r_spec_cfg),
        .o_valid    (w_f_v),
        .o_item     (w_f_item)
    );

    tps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_v),
        .i_data  (w_f_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_item),
        .o_empty (w_empty)
    );

    // advance the back whenever the output slot is free or being taken
    assign w_back_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_pop     = w_back_en && !w_empty;

    tps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_back_en),
        .i_valid        (!w_empty),
        .i_item         (w_q_item),
        .o_valid        (o_m_axis_tvalid),
        .o_normal_x     (w_nx),
        .o_normal_y     (w_ny),
        .o_normal_z     (w_nz),
        .o_area         (w_area),
        .o_plane_offset (w_off),
        .o_specularity  (w_spec),
        .o_degenerate   (w_degen)
    );

    assign o_m_axis_tdata    = {1'b0, w_spec, w_off, w_area, w_nz, w_ny, w_nx};
    assign o_m_axis_tuser[0] = w_degen;

endmodule

// File: sv/tps_front.sv
`timescale 1ns / 1ps
// Front pipeline: edges, cross product, sum of squares, normalization.
// Depends on tps_pkg.
module tps_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [tps_pkg::IN_DW-1:0] i_data,
    input  logic [1:0]                i_kind,
    input  logic [tps_pkg::SPW-1:0]   i_spec_cfg,
    output logic                      o_valid,
    output tps_pkg::t_fifo_item       o_item
);
    import tps_pkg::*;

    localparam int NS = 11;

    typedef struct packed {
        logic [23:0]    x;
        logic [23:0]    y;
        logic [23:0]    z;
        logic [SPW-1:0] spec;
    } t_pass;

    logic [NS-1:0] r_v;
    t_pass         r_pass [0:NS-1];
    logic [2:0]    r_neg  [3:NS-1];
    logic [MW-1:0] r_mag  [3:8][0:2];
    logic          r_dg   [8:NS-1];
    logic [5:0]    r_k    [8:NS-1];

    logic signed [24:0] r0_e  [0:5];
    logic signed [49:0] r1_p  [0:5];
    logic signed [50:0] r2_c  [0:2];
    logic [49:0]        r4_hh [0:2];
    logic [49:0]        r4_hl [0:2];
    logic [49:0]        r4_ll [0:2];
    logic [99:0]        r5_sq [0:2];
    logic [101:0]       r6_s;
    logic [6:0]         r7_nz;
    logic [3:0]         r7_pos [0:6];
    logic [101:0]       r7_s;
    logic [101:0]       r8_s;
    logic [6:0]         r8_sh;
    logic [XW-1:0]      r9_x;
    logic [NW-1:0]      r9_num [0:2];
    logic [3:0]         r9_sh4;
    logic [2:0]         r9_k3;
    logic [XW-1:0]      r10_x;
    logic [NW-1:0]      r10_num [0:2];

    logic signed [23:0] w_v [0:8];
    logic signed [24:0] w_e [0:5];
    t_pass              w_pass;
    logic [111:0]       w_sp;
    logic [6:0]         w_nz;
    logic [3:0]         w_pos [0:6];
    logic [6:0]         w_bl;
    logic [6:0]         w_kk;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_v[i] = i_data[24*i +: 24];
        end
        for (int i = 0; i < 3; i++) begin
            w_e[i]     = 25'(w_v[i]) - 25'(w_v[i+3]);
            w_e[i + 3] = 25'(w_v[i]) - 25'(w_v[i+6]);
        end
        w_pass.x = w_v[0];
        w_pass.y = w_v[1];
        w_pass.z = w_v[2];
        if (i_kind == KIND_ORDINARY) begin
            w_pass.spec = (i_spec_cfg > ONE_Q16) ? ONE_Q16 : i_spec_cfg;
        end else begin
            w_pass.spec = ONE_Q16;
        end
    end

    // leading one per 16-bit chunk
    always_comb begin
        w_sp = {10'd0, r6_s};
        for (int c = 0; c < 7; c++) begin
            w_nz[c]  = |w_sp[16*c +: 16];
            w_pos[c] = 4'd0;
            for (int b = 0; b < 16; b++) begin
                if (w_sp[16*c + b]) begin
                    w_pos[c] = 4'(b);
                end
            end
        end
    end

    always_comb begin
        w_bl = 7'd0;
        for (int c = 0; c < 7; c++) begin
            if (r7_nz[c]) begin
                w_bl = 7'(16 * c) + {3'd0, r7_pos[c]} + 7'd1;
            end
        end
        w_kk = (7'd124 - w_bl) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass[0] <= w_pass;
            for (int s = 1; s < NS; s++) begin
                r_pass[s] <= r_pass[s-1];
            end
            for (int i = 0; i < 6; i++) begin
                r0_e[i] <= w_e[i];
            end
            // a = ey2*ez3 - ez2*ey3, b = ez2*ex3 - ex2*ez3, c = ex2*ey3 - ey2*ex3
            r1_p[0] <= r0_e[1] * r0_e[5];
            r1_p[1] <= r0_e[2] * r0_e[4];
            r1_p[2] <= r0_e[2] * r0_e[3];
            r1_p[3] <= r0_e[0] * r0_e[5];
            r1_p[4] <= r0_e[0] * r0_e[4];
            r1_p[5] <= r0_e[1] * r0_e[3];
            for (int i = 0; i < 3; i++) begin
                r2_c[i] <= 51'(r1_p[2*i]) - 51'(r1_p[2*i+1]);
                r_mag[3][i] <= r2_c[i][50] ? MW'(-r2_c[i]) : MW'(r2_c[i]);
                r4_hh[i] <= r_mag[3][i][49:25] * r_mag[3][i][49:25];
                r4_hl[i] <= r_mag[3][i][49:25] * r_mag[3][i][24:0];
                r4_ll[i] <= r_mag[3][i][24:0] * r_mag[3][i][24:0];
                r5_sq[i] <= {r4_hh[i], 50'd0} + {24'd0, r4_hl[i], 26'd0}
                          + {50'd0, r4_ll[i]};
                r9_num[i] <= NW'(r_mag[8][i]) << {r_k[8][5:3], 3'd0};
                r10_num[i] <= r9_num[i] << r9_k3;
            end
            r_neg[3] <= {r2_c[2][50], r2_c[1][50], r2_c[0][50]};
            for (int s = 4; s < NS; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            for (int s = 4; s <= 8; s++) begin
                r_mag[s] <= r_mag[s-1];
            end
            r6_s   <= {2'd0, r5_sq[0]} + {2'd0, r5_sq[1]} + {2'd0, r5_sq[2]};
            r7_nz  <= w_nz;
            r7_pos <= w_pos;
            r7_s   <= r6_s;
            r8_s   <= r7_s;
            r8_sh  <= {w_kk[5:0], 1'b0};
            r_k[8] <= w_kk[5:0];
            r_dg[8] <= ~|r7_nz;
            for (int s = 9; s < NS; s++) begin
                r_k[s]  <= r_k[s-1];
                r_dg[s] <= r_dg[s-1];
            end
            r9_x   <= {22'd0, r8_s} << {r8_sh[6:4], 4'd0};
            r9_sh4 <= r8_sh[3:0];
            r9_k3  <= r_k[8][2:0];
            r10_x  <= r9_x << r9_sh4;
        end
    end

    always_comb begin
        o_valid          = r_v[NS-1];
        o_item.x         = r10_x;
        for (int i = 0; i < 3; i++) begin
            o_item.side.num[i] = r10_num[i];
        end
        o_item.side.neg   = r_neg[NS-1];
        o_item.side.k     = r_k[NS-1];
        o_item.side.v1x   = r_pass[NS-1].x;
        o_item.side.v1y   = r_pass[NS-1].y;
        o_item.side.v1z   = r_pass[NS-1].z;
        o_item.side.spec  = r_pass[NS-1].spec;
        o_item.side.degen = r_dg[NS-1];
    end

endmodule

// File: sv/tps_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front and back pipelines.
// Depends on tps_pkg.
module tps_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tps_pkg::t_fifo_item i_data,
    output logic                o_full,
    input  logic                i_pop,
    output tps_pkg::t_fifo_item o_data,
    output logic                o_empty
);
    import tps_pkg::*;

    t_fifo_item         r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_PW-1:0] r_wp;
    logic [FIFO_PW-1:0] r_rp;
    logic [FIFO_PW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (FIFO_PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + FIFO_PW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + FIFO_PW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (FIFO_PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (FIFO_PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/tps_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on tps_pkg.
module tps_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [tps_pkg::XW-1:0] i_x,
    input  tps_pkg::t_sq_side    i_side,
    output logic                 o_valid,
    output logic [tps_pkg::LW-1:0] o_root,
    output tps_pkg::t_sq_side    o_side
);
    import tps_pkg::*;

    logic [LW:0]   r_v;
    logic [LW-1:0] r_q    [0:LW];
    logic [63:0]   r_r    [0:LW];
    logic [XW-1:0] r_x    [0:LW];
    t_sq_side      r_side [0:LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]    <= '0;
            r_r[0]    <= '0;
            r_x[0]    <= i_x;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < LW; s++) begin : g_stage
        logic [65:0] w_rr;
        logic [65:0] w_t;
        logic        w_ge;

        always_comb begin
            w_rr = {r_r[s], r_x[s][XW-1-2*s -: 2]};
            w_t  = {2'b00, r_q[s], 2'b01};
            w_ge = (w_rr >= w_t);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]    <= {r_q[s][LW-2:0], w_ge};
                r_r[s+1]    <= w_ge ? 64'(w_rr - w_t) : w_rr[63:0];
                r_x[s+1]    <= r_x[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[LW];
    assign o_root  = r_q[LW];
    assign o_side  = r_side[LW];

endmodule

// File: sv/tps_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: three numerators over one shared divisor.
// Depends on tps_pkg.
module tps_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][tps_pkg::NW-1:0]     i_num,
    input  logic [tps_pkg::LW-1:0]          i_den,
    input  tps_pkg::t_div_side              i_side,
    output logic                            o_valid,
    output logic [2:0][tps_pkg::QW-1:0]     o_quo,
    output tps_pkg::t_div_side              o_side
);
    import tps_pkg::*;

    logic [QW:0]          r_v;
    logic [2:0][NW:0]     r_r    [0:QW];
    logic [2:0][QW-1:0]   r_q    [0:QW];
    logic [LW-1:0]        r_d    [0:QW];
    t_div_side            r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_r[0][c] <= {1'b0, i_num[c]};
            end
            r_q[0]    <= '0;
            r_d[0]    <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [2:0]       w_ge;
        logic [2:0][NW:0] w_rem;

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_ge[c]  = (r_r[s][c] >= {1'b0, r_d[s]});
                w_rem[c] = w_ge[c] ? (r_r[s][c] - {1'b0, r_d[s]}) : r_r[s][c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_r[s+1][c] <= {w_rem[c][NW-1:0], 1'b0};
                    r_q[s+1][c] <= {r_q[s][c][QW-2:0], w_ge[c]};
                end
                r_d[s+1]    <= r_d[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_side  = r_side[QW];

endmodule

// File: sv/tps_back.sv
`timescale 1ns / 1ps
// Back pipeline: square root, area, normal division, plane offset, output register.
// Depends on tps_pkg, tps_sqrt and tps_div.
module tps_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  tps_pkg::t_fifo_item        i_item,
    output logic                       o_valid,
    output logic [31:0]                o_normal_x,
    output logic [31:0]                o_normal_y,
    output logic [31:0]                o_normal_z,
    output logic [tps_pkg::MW-1:0]     o_area,
    output logic [43:0]                o_plane_offset,
    output logic [tps_pkg::SPW-1:0]    o_specularity,
    output logic                       o_degenerate
);
    import tps_pkg::*;

    typedef struct packed {
        logic [MW-1:0]  area;
        logic [SPW-1:0] spec;
        logic           degen;
    } t_out_side;

    logic               w_sq_v;
    logic [LW-1:0]      w_root;
    t_sq_side           w_sq_side;
    t_div_side          w_a_side;

    logic               r_a_v;
    logic [2:0][NW-1:0] r_a_num;
    logic [LW-1:0]      r_a_den;
    t_div_side          r_a_side;

    logic               w_d_v;
    logic [2:0][QW-1:0] w_quo;
    t_div_side          w_d_side;

    logic               r_m0_v, r_m1_v, r_m2_v, r_out_v;
    logic signed [31:0] r_m0_n [0:2];
    logic signed [31:0] r_m1_n [0:2];
    logic signed [31:0] r_m2_n [0:2];
    logic signed [31:0] r_out_n [0:2];
    logic signed [23:0] r_m0_vtx [0:2];
    logic signed [55:0] r_m1_p [0:2];
    logic signed [57:0] r_m2_dot;
    t_out_side          r_m0_s, r_m1_s, r_m2_s, r_out_s;
    logic [43:0]        r_out_off;

    logic signed [31:0] w_n [0:2];
    logic [QW-1:0]      w_qc [0:2];
    logic [56:0]        w_mag;
    logic [43:0]        w_m;

    tps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_x     (i_item.x),
        .i_side  (i_item.side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    always_comb begin
        w_a_side.neg   = w_sq_side.neg;
        w_a_side.area  = MW'((w_root >> w_sq_side.k) >> 1);
        w_a_side.v1x   = w_sq_side.v1x;
        w_a_side.v1y   = w_sq_side.v1y;
        w_a_side.v1z   = w_sq_side.v1z;
        w_a_side.spec  = w_sq_side.spec;
        w_a_side.degen = w_sq_side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_num  <= w_sq_side.num;
            r_a_den  <= w_root;
            r_a_side <= w_a_side;
        end
    end

    tps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_a_v),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_side  (r_a_side),
        .o_valid (w_d_v),
        .o_quo   (w_quo),
        .o_side  (w_d_side)
    );

    // clamp to 1.0, apply sign, zero on a degenerate triangle
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qc[i] = (w_quo[i] > ONE_Q30) ? ONE_Q30 : w_quo[i];
            if (w_d_side.degen) begin
                w_n[i] = '0;
            end else if (w_d_side.neg[i]) begin
                w_n[i] = -$signed({1'b0, w_qc[i]});
            end else begin
                w_n[i] = $signed({1'b0, w_qc[i]});
            end
        end
    end

    // round |dot| to nearest at scale 2^30, then negate
    always_comb begin
        w_mag = r_m2_dot[57] ? 57'(-r_m2_dot) : 57'(r_m2_dot);
        w_m   = 44'((w_mag + 57'd2048) >> 12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_m0_v  <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= w_sq_v;
            r_m0_v  <= w_d_v;
            r_m1_v  <= r_m0_v;
            r_m2_v  <= r_m1_v;
            r_out_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0_n      <= w_n;
            r_m0_vtx[0] <= $signed(w_d_side.v1x);
            r_m0_vtx[1] <= $signed(w_d_side.v1y);
            r_m0_vtx[2] <= $signed(w_d_side.v1z);
            r_m0_s.area  <= w_d_side.area;
            r_m0_s.spec  <= w_d_side.spec;
            r_m0_s.degen <= w_d_side.degen;
            for (int i = 0; i < 3; i++) begin
                r_m1_p[i] <= r_m0_vtx[i] * r_m0_n[i];
            end
            r_m1_n    <= r_m0_n;
            r_m1_s    <= r_m0_s;
            r_m2_dot  <= 58'(r_m1_p[0]) + 58'(r_m1_p[1]) + 58'(r_m1_p[2]);
            r_m2_n    <= r_m1_n;
            r_m2_s    <= r_m1_s;
            r_out_off <= ($signed(r_m2_dot) > 58'sd0) ? -w_m : w_m;
            r_out_n   <= r_m2_n;
            r_out_s   <= r_m2_s;
        end
    end

    assign o_valid        = r_out_v;
    assign o_normal_x     = r_out_n[0];
    assign o_normal_y     = r_out_n[1];
    assign o_normal_z     = r_out_n[2];
    assign o_area         = r_out_s.area;
    assign o_plane_offset = r_out_off;
    assign o_specularity  = r_out_s.spec;
    assign o_degenerate   = r_out_s.degen;

endmodule
